// File: hw/rtl/gha_pkg.sv
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types and constants for the generational handle allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

  localparam int unsigned MaxHandles = 1024;
  localparam int unsigned IdW        = $clog2(MaxHandles);
  localparam int unsigned CntW       = IdW + 1;
  localparam int unsigned GenW       = 16;

  typedef enum logic [1:0] {
    OP_CREATE  = 2'd0,
    OP_DESTROY = 2'd1,
    OP_CHECK   = 2'd2,
    OP_LOOKUP  = 2'd3
  } gha_op_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_REJECT = 2'd2
  } gha_status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_READ,
    FSM_ALLOC,
    FSM_FIX
  } gha_fsm_e;

  typedef struct packed {
    gha_op_e             cmd;
    logic [IdW-1:0]      handle_id;
    logic [GenW-1:0]     handle_generation;
  } gha_req_t;

  typedef struct packed {
    gha_status_e         status;
    logic [IdW-1:0]      out_id;
    logic [GenW-1:0]     out_generation;
    logic                is_live;
    logic [CntW-1:0]     high_water;
    logic [CntW-1:0]     live_count;
  } gha_rsp_t;

  // Per-id record: active bit, generation, position in the dense list.
  typedef struct packed {
    logic                active;
    logic [GenW-1:0]     gen;
    logic [IdW-1:0]      pos;
  } gha_rec_t;

  // Dense member list entry.
  typedef struct packed {
    logic [IdW-1:0]      id;
    logic [GenW-1:0]     gen;
  } gha_dense_t;

endpackage

// File: hw/rtl/generational_handle_allocator_unit.sv
// ----------------------------------------------------------------------------
// generational_handle_allocator_unit
// Handle allocator with per-id generation counters, LIFO id reuse and a
// dense member list kept compact by swap-and-pop.
// ----------------------------------------------------------------------------
//
//  channel    | ports                       | handshake
//  -----------+-----------------------------+--------------------------------
//  command    | start, req_i                | beat taken when start && !busy
//  result     | done_o, rsp_o               | one-cycle strobe, no stall
//  config     | cfg_we_i, cfg_wdata_i       | written on any cycle with we
//
// Command steps: check, lookup and create of a fresh id finish in the read
// state; destroy adds a fix state when the last dense entry has to move; create
// that reuses a freed id adds an alloc state (free stack read, then record read
// of the popped id). The single write port of the record memory and the
// dependent record read of a reused id make these extra states necessary.
// Result strobe rises the cycle after the last command cycle; a new command
// can be taken in that same cycle.
// Reset clears control only; no memory sweep is needed. A record is trusted
// only below the high-water mark: ids at or above it were never handed out
// and read as generation 0, inactive.
// ----------------------------------------------------------------------------
module generational_handle_allocator_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  gha_pkg::gha_req_t req_i,
  output logic              done_o,
  output gha_pkg::gha_rsp_t rsp_o,
  input  logic              cfg_we_i,
  input  logic [10:0]       cfg_wdata_i
);
  import gha_pkg::*;

  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxHandles);

  // storage
  gha_rec_t          rec_mem   [MaxHandles];
  gha_dense_t        dense_mem [MaxHandles];
  logic [IdW-1:0]    stack_mem [MaxHandles];

  // control state
  gha_fsm_e          state_q, state_d;
  gha_req_t          op_q;
  logic [CntW-1:0]   cap_q;
  logic [CntW-1:0]   fresh_q, fresh_d;     // high-water mark
  logic [CntW-1:0]   free_q, free_d;       // free stack depth
  logic [CntW-1:0]   dcnt_q, dcnt_d;       // dense list length
  logic              done_q, done_d;
  gha_rsp_t          rsp_q, rsp_d;

  // registered read data
  gha_rec_t          rec_rd_q;
  gha_dense_t        dense_rd_q;
  logic [IdW-1:0]    stack_rd_q;

  // memory controls
  logic              rec_re, rec_we, dense_re, dense_we, stack_re, stack_we;
  logic [IdW-1:0]    rec_raddr, rec_waddr, dense_waddr, stack_waddr;
  gha_rec_t          rec_wdata;
  gha_dense_t        dense_wdata;
  logic [IdW-1:0]    stack_wdata;

  // decode
  logic              accept;
  logic [CntW-1:0]   cap_used, last;
  logic              id_ok, rec_known, hit, pop, fresh_ok, move;
  logic [GenW-1:0]   gen_bump;

  assign busy     = (state_q != FSM_IDLE);
  assign accept   = start && !busy;
  assign cap_used = (cap_q > MaxCnt) ? MaxCnt : cap_q;
  assign last     = dcnt_q - CntW'(1);
  assign id_ok    = (op_q.handle_id != '0) && ({1'b0, op_q.handle_id} < cap_used);
  assign rec_known = {1'b0, op_q.handle_id} < fresh_q;
  assign hit      = id_ok && rec_known && rec_rd_q.active &&
                    (rec_rd_q.gen == op_q.handle_generation);
  assign pop      = (free_q != '0);
  assign fresh_ok = fresh_q < cap_used;
  assign move     = {1'b0, rec_rd_q.pos} < last;
  assign gen_bump = rec_rd_q.gen + GenW'(1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (accept) state_d = FSM_READ;
      end
      FSM_READ: begin
        case (op_q.cmd)
          OP_CREATE:  state_d = pop ? FSM_ALLOC : FSM_IDLE;
          OP_DESTROY: state_d = (hit && (dcnt_q != '0) && move) ? FSM_FIX : FSM_IDLE;
          default:    state_d = FSM_IDLE;
        endcase
      end
      FSM_ALLOC: state_d = FSM_IDLE;
      FSM_FIX:   state_d = FSM_IDLE;
      default:   state_d = FSM_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    rec_re      = 1'b0;
    dense_re    = 1'b0;
    stack_re    = 1'b0;
    rec_we      = 1'b0;
    dense_we    = 1'b0;
    stack_we    = 1'b0;
    rec_raddr   = req_i.handle_id;
    rec_waddr   = op_q.handle_id;
    rec_wdata   = rec_rd_q;
    dense_waddr = dcnt_q[IdW-1:0];
    dense_wdata = dense_rd_q;
    stack_waddr = free_q[IdW-1:0];
    stack_wdata = op_q.handle_id;
    fresh_d     = fresh_q;
    free_d      = free_q;
    dcnt_d      = dcnt_q;
    done_d      = 1'b0;
    rsp_d       = '0;
    rsp_d.status = ST_DONE;

    case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          // record, last dense entry and top of free stack in parallel
          rec_re   = 1'b1;
          dense_re = 1'b1;
          stack_re = 1'b1;
        end
      end

      FSM_READ: begin
        case (op_q.cmd)
          OP_CREATE: begin
            if (pop) begin
              // reuse freed id: fetch its record next
              free_d    = free_q - CntW'(1);
              rec_re    = 1'b1;
              rec_raddr = stack_rd_q;
            end else if (fresh_ok && (dcnt_q != MaxCnt)) begin
              // fresh id: never written, old generation is zero
              rec_we      = 1'b1;
              rec_waddr   = fresh_q[IdW-1:0];
              rec_wdata   = '{active: 1'b1, gen: GenW'(1), pos: dcnt_q[IdW-1:0]};
              dense_we    = 1'b1;
              dense_wdata = '{id: fresh_q[IdW-1:0], gen: GenW'(1)};
              dcnt_d      = dcnt_q + CntW'(1);
              fresh_d     = fresh_q + CntW'(1);
              rsp_d.out_id         = fresh_q[IdW-1:0];
              rsp_d.out_generation = GenW'(1);
              rsp_d.is_live        = 1'b1;
              done_d      = 1'b1;
            end else begin
              if (fresh_ok) fresh_d = fresh_q + CntW'(1);
              rsp_d.status = ST_FULL;
              done_d       = 1'b1;
            end
          end

          OP_DESTROY: begin
            if (hit && (dcnt_q != '0)) begin
              rec_we    = 1'b1;
              rec_wdata = '{active: 1'b0, gen: rec_rd_q.gen, pos: rec_rd_q.pos};
              if (free_q != MaxCnt) begin
                stack_we = 1'b1;
                free_d   = free_q + CntW'(1);
              end
              if (move) begin
                // last entry fills the hole; its record is fixed next cycle
                dense_we    = 1'b1;
                dense_waddr = rec_rd_q.pos;
              end else begin
                done_d = 1'b1;
              end
              dcnt_d        = last;
              rsp_d.is_live = 1'b1;
            end else begin
              rsp_d.status = ST_REJECT;
              done_d       = 1'b1;
            end
          end

          OP_CHECK: begin
            if (hit) rsp_d.is_live = 1'b1;
            else     rsp_d.status  = ST_REJECT;
            done_d = 1'b1;
          end

          OP_LOOKUP: begin
            if (id_ok) begin
              rsp_d.out_id         = op_q.handle_id;
              rsp_d.out_generation = rec_known ? rec_rd_q.gen : '0;
              rsp_d.is_live        = rec_known && rec_rd_q.active;
            end else begin
              rsp_d.status = ST_REJECT;
            end
            done_d = 1'b1;
          end

          default: begin
            rsp_d.status = ST_REJECT;
            done_d       = 1'b1;
          end
        endcase
      end

      FSM_ALLOC: begin
        if (dcnt_q != MaxCnt) begin
          rec_we      = 1'b1;
          rec_waddr   = stack_rd_q;
          rec_wdata   = '{active: 1'b1, gen: gen_bump, pos: dcnt_q[IdW-1:0]};
          dense_we    = 1'b1;
          dense_wdata = '{id: stack_rd_q, gen: gen_bump};
          dcnt_d      = dcnt_q + CntW'(1);
          rsp_d.out_id         = stack_rd_q;
          rsp_d.out_generation = gen_bump;
          rsp_d.is_live        = 1'b1;
        end else begin
          rsp_d.status = ST_FULL;
        end
        done_d = 1'b1;
      end

      FSM_FIX: begin
        // moved handle now sits at the destroyed one's position
        rec_we        = 1'b1;
        rec_waddr     = dense_rd_q.id;
        rec_wdata     = '{active: 1'b1, gen: dense_rd_q.gen, pos: rec_rd_q.pos};
        rsp_d.is_live = 1'b1;
        done_d        = 1'b1;
      end

      default: ;
    endcase

    rsp_d.high_water = fresh_d;
    rsp_d.live_count = dcnt_d;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
      cap_q   <= MaxCnt;
      fresh_q <= CntW'(1);
      free_q  <= '0;
      dcnt_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      fresh_q <= fresh_d;
      free_q  <= free_d;
      dcnt_q  <= dcnt_d;
      done_q  <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) op_q <= req_i;
    if (done_d) rsp_q <= rsp_d;
  end

  // record memory
  always_ff @(posedge clk_i) begin
    if (rec_we) rec_mem[rec_waddr] <= rec_wdata;
    if (rec_re) rec_rd_q <= rec_mem[rec_raddr];
  end

  // dense list memory
  always_ff @(posedge clk_i) begin
    if (dense_we) dense_mem[dense_waddr] <= dense_wdata;
    if (dense_re) dense_rd_q <= dense_mem[last[IdW-1:0]];
  end

  // free stack memory
  always_ff @(posedge clk_i) begin
    if (stack_we) stack_mem[stack_waddr] <= stack_wdata;
    if (stack_re) stack_rd_q <= stack_mem[stack_waddr - IdW'(1)];
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
